/* hdl/srecord_stream_loader_defines.svh */
// Assertion macros for the S-record stream loader.
`ifndef SRECORD_STREAM_LOADER_DEFINES_SVH
`define SRECORD_STREAM_LOADER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SRSL_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("srsl assertion failed");

`define SRSL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("srsl assertion failed");

`else

`define SRSL_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define SRSL_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

/* hdl/srsl_pkg.sv */
// Types and constants shared by the S-record stream loader.
package srsl_pkg;

   // line length limit and the width of the line position counter
   localparam int LINE_MAX = 100;
   localparam int POS_W    = $clog2(LINE_MAX + 1);

   localparam logic [31:0] LIMIT_RESET = 32'd24576;

   // result kinds
   localparam logic RSP_WRITE = 1'b0;
   localparam logic RSP_DONE  = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_S     = 8'd83;
   localparam logic [7:0] CHAR_ONE   = 8'd49;
   localparam logic [7:0] CHAR_THREE = 8'd51;
   localparam logic [7:0] CHAR_LOW   = 8'd31;
   localparam logic [7:0] CHAR_HIGH  = 8'd127;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_A     = 8'd65;
   localparam logic [7:0] CHAR_F     = 8'd70;
   localparam logic [7:0] ALPHA_BIAS = 8'd55;

   localparam logic [7:0] PAIR_SAT = 8'd255;

   typedef enum logic [1:0] {
      REC_NONE  = 2'd0,
      REC_SAW_S = 2'd1,
      REC_S1    = 2'd2,
      REC_S3    = 2'd3
   } rec_kind_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [7:0]  data;
      logic [31:0] image_length;
   } rsp_type;

   // classification of one character
   typedef struct packed {
      logic       terminator;
      logic       is_s;
      logic       is_one;
      logic       is_three;
      logic       digit_bad;
      logic [3:0] digit;
   } char_class_type;

endpackage

/* hdl/srsl_char_class.sv */
// Character classifier: terminator test, record type letters, hex digit decode.
module srsl_char_class
   import srsl_pkg::*;
(
   input  logic [7:0]     char_in,
   output char_class_type char_class
);

   logic       is_num;
   logic       is_alpha;
   logic [7:0] num_val;
   logic [7:0] alpha_val;

   assign is_num    = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign is_alpha  = (char_in >= CHAR_A) && (char_in <= CHAR_F);
   assign num_val   = char_in - CHAR_ZERO;
   assign alpha_val = char_in - ALPHA_BIAS;

   always_comb begin
      char_class.terminator = (char_in < CHAR_LOW) || (char_in > CHAR_HIGH);
      char_class.is_s       = (char_in == CHAR_S);
      char_class.is_one     = (char_in == CHAR_ONE);
      char_class.is_three   = (char_in == CHAR_THREE);
      char_class.digit_bad  = !(is_num || is_alpha);
      if (is_num) begin
         char_class.digit = num_val[3:0];
      end else begin
         char_class.digit = alpha_val[3:0];
      end
   end

endmodule

/* hdl/srecord_stream_loader.sv */
// Top level of the S-record stream loader.
// S-record text enters one character per request and one request can be accepted
// every clock cycle. Each character is decoded and the line state updated in a
// single pass; a memory write or done result appears in the output register in the
// cycle after its character is accepted. The next character is accepted while
// that result waits, as long as the output register is empty or is being taken.
// S1 and S3 records are loaded, other lines are skipped; an empty line or an
// end-of-input request gives a done result carrying the image length.
`include "srecord_stream_loader_defines.svh"

module srecord_stream_loader
   import srsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   // state registers
   logic [31:0]      limit_ff, limit_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   rec_kind_type     rec_ff, rec_in;
   logic [4:0]       nibble_ff, nibble_in;
   logic [7:0]       count_ff, count_in;
   logic [7:0]       pair_ff, pair_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      highest_ff, highest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic           accept;
   logic           emit;
   char_class_type cls;
   logic [2:0]     addr_bytes;
   logic           pair_ok;
   logic [7:0]     pair_val;
   logic [POS_W-1:0] pos_next;

   srsl_char_class u_char_class (
      .char_in    (req_payload.char_in),
      .char_class (cls)
   );

   // handshakes
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign addr_bytes = (rec_ff == REC_S1) ? 3'd2 : 3'd4;
   assign pair_ok    = !nibble_ff[4] && !cls.digit_bad;
   assign pair_val   = pair_ok ? {nibble_ff[3:0], cls.digit} : 8'd0;
   assign pos_next   = pos_ff + 1'b1;

   // line decode and result for one character
   always_comb begin
      limit_in   = limit_ff;
      pos_in     = pos_ff;
      rec_in     = rec_ff;
      nibble_in  = nibble_ff;
      count_in   = count_ff;
      pair_in    = pair_ff;
      addr_in    = addr_ff;
      highest_in = highest_ff;
      emit       = 1'b0;
      rsp_in     = rsp_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_wdata;
      end

      if (accept) begin
         if (req_payload.end_of_input || (cls.terminator && pos_ff == '0)) begin
            // done: report image length and clear the line state and highest address
            emit                = 1'b1;
            rsp_in.kind         = RSP_DONE;
            rsp_in.address      = '0;
            rsp_in.data         = '0;
            rsp_in.image_length = (highest_ff != '0) ? highest_ff + 32'd1 : 32'd0;
            pos_in     = '0;
            rec_in     = REC_NONE;
            nibble_in  = '0;
            count_in   = '0;
            pair_in    = '0;
            addr_in    = '0;
            highest_in = '0;
         end else if (cls.terminator) begin
            pos_in    = '0;
            rec_in    = REC_NONE;
            nibble_in = '0;
            count_in  = '0;
            pair_in   = '0;
            addr_in   = '0;
         end else begin
            if (pos_ff == '0) begin
               rec_in = cls.is_s ? REC_SAW_S : REC_NONE;
            end else if (pos_ff == POS_W'(1)) begin
               priority if (rec_ff == REC_SAW_S && cls.is_one) begin
                  rec_in = REC_S1;
               end else if (rec_ff == REC_SAW_S && cls.is_three) begin
                  rec_in = REC_S3;
               end else begin
                  rec_in = REC_NONE;
               end
            end else if (rec_ff == REC_S1 || rec_ff == REC_S3) begin
               if (!pos_ff[0]) begin
                  // first digit of a pair
                  nibble_in = {cls.digit_bad, cls.digit};
               end else begin
                  // complete pair
                  if (pair_ff != PAIR_SAT) begin
                     pair_in = pair_ff + 8'd1;
                  end
                  priority if (pair_ff == '0) begin
                     count_in = pair_val;
                  end else if (pair_ff <= {5'd0, addr_bytes}) begin
                     addr_in = {addr_ff[23:0], pair_val};
                  end else if (({1'b0, pair_ff} + 9'd1) < {1'b0, count_ff}) begin
                     if (addr_ff < limit_ff) begin
                        if (pair_ok) begin
                           emit                = 1'b1;
                           rsp_in.kind         = RSP_WRITE;
                           rsp_in.address      = addr_ff;
                           rsp_in.data         = pair_val;
                           rsp_in.image_length = '0;
                           if (addr_ff > highest_ff) begin
                              highest_in = addr_ff;
                           end
                        end
                        addr_in = addr_ff + 32'd1;
                     end
                  end else begin
                     // the last data byte, the checksum and anything after them are ignored
                  end
               end
            end
            // advance, closing a line that reached the length limit
            if (pos_next >= POS_W'(LINE_MAX)) begin
               pos_in    = '0;
               rec_in    = REC_NONE;
               nibble_in = '0;
               count_in  = '0;
               pair_in   = '0;
               addr_in   = '0;
            end else begin
               pos_in = pos_next;
            end
         end
      end

      // output register
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         pos_ff       <= '0;
         rec_ff       <= REC_NONE;
         nibble_ff    <= '0;
         count_ff     <= '0;
         pair_ff      <= '0;
         addr_ff      <= '0;
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         pos_ff       <= pos_in;
         rec_ff       <= rec_in;
         nibble_ff    <= nibble_in;
         count_ff     <= count_in;
         pair_ff      <= pair_in;
         addr_ff      <= addr_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `SRSL_ASSERT_IMPLIES(a_pos_in_range, clock, reset, 1'b1, pos_ff < POS_W'(LINE_MAX))
   `SRSL_ASSERT_IMPLIES(a_done_clean, clock, reset, rsp_valid_ff && rsp_ff.kind == RSP_DONE, rsp_ff.address == '0 && rsp_ff.data == '0)
   `SRSL_ASSERT_IMPLIES(a_write_tracked, clock, reset, rsp_valid_ff && rsp_ff.kind == RSP_WRITE, highest_ff >= rsp_ff.address)
   `SRSL_ASSERT_NEXT(a_eoi_clears, clock, reset, accept && req_payload.end_of_input, highest_ff == '0 && pos_ff == '0 && rsp_valid_ff)

endmodule
